// ===== rtl/bcu_pkg.sv =====
// ----------------------------------------------------------------------------
// bcu_pkg: shared constants for the bilinear chroma upsampler
// Field widths, register indexes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package bcu_pkg;

   // transaction field widths
   localparam int SRC_ROW_BITS   = 10;
   localparam int SRC_COL_BITS   = 10;
   localparam int SAMPLE_F_BITS  = 16;
   localparam int DST_ROW_BITS   = 11;
   localparam int DST_COL_BITS   = 11;
   localparam int VALUE_BITS     = 16;

   // configuration registers
   localparam int SRC_DIM_BITS   = 11;
   localparam int DST_DIM_BITS   = 12;
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = 12;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DST_HEIGHT = 2'd3;

   localparam logic [SRC_DIM_BITS-1:0] RST_SRC_WIDTH  = 11'd960;
   localparam logic [SRC_DIM_BITS-1:0] RST_SRC_HEIGHT = 11'd540;
   localparam logic [DST_DIM_BITS-1:0] RST_DST_WIDTH  = 12'd1920;
   localparam logic [DST_DIM_BITS-1:0] RST_DST_HEIGHT = 12'd1080;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // parameter defaults
   localparam int DEF_MAX_SRC_WIDTH  = 1024;
   localparam int DEF_MAX_SRC_HEIGHT = 1024;
   localparam int DEF_MAX_DST_WIDTH  = 2048;
   localparam int DEF_MAX_DST_HEIGHT = 2048;
   localparam int DEF_SAMPLE_BITS    = 16;

endpackage

// ===== rtl/bcu_if.sv =====
// ----------------------------------------------------------------------------
// bcu_if: channel interfaces of the bilinear chroma upsampler
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bcu_req_if
   import bcu_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic [SRC_ROW_BITS-1:0]  src_row;
   logic [SRC_COL_BITS-1:0]  src_col;
   logic [SAMPLE_F_BITS-1:0] sample;
   logic [DST_ROW_BITS-1:0]  dst_row;
   logic [DST_COL_BITS-1:0]  dst_col;

   modport source (output valid, command, src_row, src_col, sample, dst_row, dst_col,
                   input ready);
   modport sink   (input valid, command, src_row, src_col, sample, dst_row, dst_col,
                   output ready);
endinterface

interface bcu_rsp_if
   import bcu_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, value, input ready);
   modport sink   (input valid, value, output ready);
endinterface

interface bcu_csr_if
   import bcu_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bcu_div.sv =====
// ----------------------------------------------------------------------------
// bcu_div: shared restoring divider
// One quotient bit per cycle; quotient must be known to fit in QB bits.
// ----------------------------------------------------------------------------
module bcu_div
   import bcu_pkg::*;
#(
   parameter int DVB = 60,
   parameter int QB  = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVB-1:0] dividend,
   input  logic [DVB-1:0] divisor,
   output logic           done,
   output logic [QB-1:0]  quot,
   output logic [DVB-1:0] rem
);

   localparam int CB = $clog2(QB + 1);

   logic [DVB-1:0] rem_ff, rem_in;
   logic [DVB-1:0] dsh_ff, dsh_in;
   logic [QB-1:0]  quot_ff, quot_in;
   logic [CB-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic           ge;

   // one compare and subtract per step
   assign ge = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = divisor << (QB - 1);
         quot_in = '0;
         cnt_in  = CB'(QB);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = ge ? (rem_ff - dsh_ff) : rem_ff;
         dsh_in  = dsh_ff >> 1;
         quot_in = {quot_ff[QB-2:0], ge};
         cnt_in  = cnt_ff - CB'(1);
         if (cnt_ff == CB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// ===== rtl/bcu_mem.sv =====
// ----------------------------------------------------------------------------
// bcu_mem: source plane storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bcu_mem
   import bcu_pkg::*;
#(
   parameter int DEPTH = 1048576,
   parameter int AW    = 20,
   parameter int DW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bilinear_chroma_upsampler.sv =====
// ----------------------------------------------------------------------------
// bilinear_chroma_upsampler: bilinear resampler over a stored chroma plane
//
// req_bus carries commands. A write (command 0) stores sample at
// (src_row, src_col) and gives no response; the next request is taken in the
// following cycle. A read (command 1) maps (dst_row, dst_col) onto the source
// grid, fetches the four neighbors and returns one rounded sample on rsp_bus.
// A read runs two serial divides onto the source grid, four neighbor reads
// through the one read port, multiply and sum, and a final rounding divide,
// all on one divider of QB quotient bits (max of SAMPLE_BITS and the source
// index widths). One read is in flight at a time; no request is taken until
// it finishes. Writes outside the maximum source plane are dropped.
// csr_bus writes the four size registers; it is always ready and must only be
// used while the block is idle.
// Reset is synchronous: sizes return to 960x540 -> 1920x1080 and the response
// register empties; the source plane is not cleared.
// If rsp_bus stalls, the finished result waits in the response register; a
// following read completes its final divide and then holds until it is taken.
// ----------------------------------------------------------------------------
module bilinear_chroma_upsampler
   import bcu_pkg::*;
#(
   parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
   parameter int MAX_DST_WIDTH  = DEF_MAX_DST_WIDTH,
   parameter int MAX_DST_HEIGHT = DEF_MAX_DST_HEIGHT,
   parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
   input  logic     clock,
   input  logic     reset,
   bcu_req_if.sink  req_bus,
   bcu_rsp_if.source rsp_bus,
   bcu_csr_if.sink  csr_bus
);

   localparam int SWB  = $clog2(MAX_SRC_WIDTH + 1);
   localparam int SHB  = $clog2(MAX_SRC_HEIGHT + 1);
   localparam int DWB  = $clog2(MAX_DST_WIDTH + 1);
   localparam int DHB  = $clog2(MAX_DST_HEIGHT + 1);
   localparam int IXB  = $clog2(MAX_SRC_WIDTH);
   localparam int IYB  = $clog2(MAX_SRC_HEIGHT);
   localparam int PXB  = DST_COL_BITS + SWB;
   localparam int PYB  = DST_ROW_BITS + SHB;
   localparam int WB   = DWB + DHB;
   localparam int PB   = SAMPLE_BITS + WB;
   localparam int NUMB = PB + 2;
   localparam int QB   = (SAMPLE_BITS >= IXB && SAMPLE_BITS >= IYB) ? SAMPLE_BITS :
                         (IXB >= IYB) ? IXB : IYB;
   localparam int DVB  = QB + WB + SAMPLE_BITS + 4;
   localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int AW   = $clog2(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_DIVX, S_DIVY, S_RD, S_MUL, S_SUM, S_DIVN
   } state_type;

   // configuration registers
   logic [SRC_DIM_BITS-1:0] src_width_ff, src_height_ff;
   logic [DST_DIM_BITS-1:0] dst_width_ff, dst_height_ff;

   // saturated sizes
   logic [SWB-1:0] sw_sat;
   logic [SHB-1:0] sh_sat;
   logic [DWB-1:0] dw_sat;
   logic [DHB-1:0] dh_sat;

   state_type state_ff, state_in;
   logic      start_ff, start_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;

   logic [PXB-1:0] px_ff, px_in;
   logic [PYB-1:0] py_ff, py_in;
   logic [IXB-1:0] ix_ff, ix_in;
   logic [IYB-1:0] iy_ff, iy_in;
   logic [DWB-1:0] rx_ff, rx_in;
   logic [DHB-1:0] ry_ff, ry_in;
   logic [2:0]     rd_cnt_ff, rd_cnt_in;
   logic [SAMPLE_BITS-1:0] v_ff [4];
   logic [WB-1:0]  w_ff [4];
   logic [WB-1:0]  w_in [4];
   logic [WB-1:0]  den_ff, den_in;
   logic [PB-1:0]  prod_ff [4];
   logic [NUMB-1:0] num_ff, num_in;

   logic [DST_COL_BITS-1:0] x_cl;
   logic [DST_ROW_BITS-1:0] y_cl;
   logic [IXB-1:0] ix1;
   logic [IYB-1:0] iy1;
   logic [DWB-1:0] wx0;
   logic [DHB-1:0] wy0;

   logic req_fire, rsp_fire, rd_cmd, wr_cmd;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [IYB-1:0] rd_row;
   logic [IXB-1:0] rd_col;
   logic [SAMPLE_BITS-1:0] rd_data;

   logic           div_done;
   logic [QB-1:0]  div_quot;
   logic [DVB-1:0] div_rem, div_dividend, div_divisor;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid & req_bus.ready;
   assign rd_cmd        = req_fire & (req_bus.command == CMD_READ);
   assign wr_cmd        = req_fire & (req_bus.command == CMD_WRITE) &
                          (32'(req_bus.src_row) < MAX_SRC_HEIGHT) &
                          (32'(req_bus.src_col) < MAX_SRC_WIDTH);
   assign rsp_fire      = rsp_valid_ff & rsp_bus.ready;
   assign csr_bus.ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= RST_SRC_WIDTH;
         src_height_ff <= RST_SRC_HEIGHT;
         dst_width_ff  <= RST_DST_WIDTH;
         dst_height_ff <= RST_DST_HEIGHT;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_SRC_WIDTH:  src_width_ff  <= SRC_DIM_BITS'(csr_bus.data);
            CSR_SRC_HEIGHT: src_height_ff <= SRC_DIM_BITS'(csr_bus.data);
            CSR_DST_WIDTH:  dst_width_ff  <= csr_bus.data;
            CSR_DST_HEIGHT: dst_height_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // sizes clamped to [1, max]
   assign sw_sat = (src_width_ff == '0) ? SWB'(1) :
                   (32'(src_width_ff) > MAX_SRC_WIDTH) ? SWB'(MAX_SRC_WIDTH) :
                   SWB'(src_width_ff);
   assign sh_sat = (src_height_ff == '0) ? SHB'(1) :
                   (32'(src_height_ff) > MAX_SRC_HEIGHT) ? SHB'(MAX_SRC_HEIGHT) :
                   SHB'(src_height_ff);
   assign dw_sat = (dst_width_ff == '0) ? DWB'(1) :
                   (32'(dst_width_ff) > MAX_DST_WIDTH) ? DWB'(MAX_DST_WIDTH) :
                   DWB'(dst_width_ff);
   assign dh_sat = (dst_height_ff == '0) ? DHB'(1) :
                   (32'(dst_height_ff) > MAX_DST_HEIGHT) ? DHB'(MAX_DST_HEIGHT) :
                   DHB'(dst_height_ff);

   // destination position clamped into the plane
   assign x_cl = (32'(req_bus.dst_col) >= 32'(dw_sat)) ?
                 DST_COL_BITS'(32'(dw_sat) - 1) : req_bus.dst_col;
   assign y_cl = (32'(req_bus.dst_row) >= 32'(dh_sat)) ?
                 DST_ROW_BITS'(32'(dh_sat) - 1) : req_bus.dst_row;

   // second neighbor, clamped at right and bottom edges
   assign ix1 = (32'(ix_ff) + 1 < 32'(sw_sat)) ? IXB'(32'(ix_ff) + 1) :
                IXB'(32'(sw_sat) - 1);
   assign iy1 = (32'(iy_ff) + 1 < 32'(sh_sat)) ? IYB'(32'(iy_ff) + 1) :
                IYB'(32'(sh_sat) - 1);

   // divider operand select
   always_comb begin
      case (state_ff)
         S_DIVX: begin
            div_dividend = DVB'(px_ff);
            div_divisor  = DVB'(dw_sat);
         end
         S_DIVY: begin
            div_dividend = DVB'(py_ff);
            div_divisor  = DVB'(dh_sat);
         end
         default: begin
            div_dividend = (DVB'(num_ff) << 1) + DVB'(den_ff);
            div_divisor  = DVB'(den_ff) << 1;
         end
      endcase
   end

   // neighbor addressing: bit 0 picks column, bit 1 picks row
   assign rd_row  = rd_cnt_ff[1] ? iy1 : iy_ff;
   assign rd_col  = rd_cnt_ff[0] ? ix1 : ix_ff;
   assign rd_addr = AW'(rd_row) * AW'(MAX_SRC_WIDTH) + AW'(rd_col);
   assign wr_addr = AW'(req_bus.src_row) * AW'(MAX_SRC_WIDTH) + AW'(req_bus.src_col);

   // blend weights
   assign wx0 = dw_sat - rx_ff;
   assign wy0 = dh_sat - ry_ff;
   always_comb begin
      w_in[0] = WB'(wx0) * WB'(wy0);
      w_in[1] = WB'(rx_ff) * WB'(wy0);
      w_in[2] = WB'(wx0) * WB'(ry_ff);
      w_in[3] = WB'(rx_ff) * WB'(ry_ff);
      den_in  = WB'(dw_sat) * WB'(dh_sat);
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_fire;
      value_in     = value_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      ix_in        = ix_ff;
      iy_in        = iy_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rd_cnt_in    = rd_cnt_ff;
      num_in       = num_ff;
      case (state_ff)
         S_IDLE: begin
            if (rd_cmd) begin
               px_in    = PXB'(x_cl) * PXB'(sw_sat);
               py_in    = PYB'(y_cl) * PYB'(sh_sat);
               start_in = 1'b1;
               state_in = S_DIVX;
            end
         end
         S_DIVX: begin
            if (div_done && !start_ff) begin
               ix_in    = IXB'(div_quot);
               rx_in    = DWB'(div_rem);
               start_in = 1'b1;
               state_in = S_DIVY;
            end
         end
         S_DIVY: begin
            if (div_done && !start_ff) begin
               iy_in     = IYB'(div_quot);
               ry_in     = DHB'(div_rem);
               rd_cnt_in = '0;
               state_in  = S_RD;
            end
         end
         S_RD: begin
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff == 3'd4) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            num_in   = NUMB'(prod_ff[0]) + NUMB'(prod_ff[1]) +
                       NUMB'(prod_ff[2]) + NUMB'(prod_ff[3]);
            start_in = 1'b1;
            state_in = S_DIVN;
         end
         S_DIVN: begin
            if (div_done && !start_ff && (!rsp_valid_ff || rsp_bus.ready)) begin
               rsp_valid_in = 1'b1;
               value_in     = VALUE_BITS'(div_quot);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_cnt_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_cnt_ff    <= rd_cnt_in;
      end
      value_ff <= value_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      ix_ff    <= ix_in;
      iy_ff    <= iy_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      num_ff   <= num_in;
   end

   // neighbor capture, weights and products
   always_ff @(posedge clock) begin
      if (state_ff == S_RD) begin
         if (rd_cnt_ff != 3'd0) begin
            v_ff[2'(rd_cnt_ff - 3'd1)] <= rd_data;
         end
         w_ff   <= w_in;
         den_ff <= den_in;
      end
      if (state_ff == S_MUL) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= PB'(v_ff[k]) * PB'(w_ff[k]);
         end
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.value = value_ff;

   bcu_div #(
      .DVB (DVB),
      .QB  (QB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   bcu_mem #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (SAMPLE_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_cmd),
      .wr_addr (wr_addr),
      .wr_data (SAMPLE_BITS'(req_bus.sample)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== rtl/bcu_chk.sv =====
// ----------------------------------------------------------------------------
// bcu_chk: port-level checks of the bilinear chroma upsampler
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module bcu_chk
   import bcu_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_command,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [VALUE_BITS-1:0] rsp_value
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("response changed while stalled");

   // a read keeps the block busy
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_READ) |=> !req_ready)
      else $error("request taken right after a read");

   // a write does not stall the request channel
   a_write_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_WRITE) |=> req_ready)
      else $error("write stalled the request channel");

   // a new response only follows a busy cycle
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without work");

endmodule

bind bilinear_chroma_upsampler bcu_chk u_bcu_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .req_command (req_bus.command),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_value   (rsp_bus.value)
);
